>>> rtl/lbrd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_pkg: shared types and constants of the lock board response deframer
// Frame layout constants, command codes, status codes and the descriptor
// that travels from the front end to the back end.
// ---------------------------------------------------------------------------
package lbrd_pkg;

   // largest frame the buffer holds, in bytes
   localparam int unsigned MAX_FRAME_DEF = 64;

   // frame total = length code + header and check bytes
   localparam int unsigned HDR_BYTES  = 4;
   // wide enough for length code + 4 and for the largest buffer size
   localparam int unsigned TOT_W      = 10;
   // bytes 3 .. 10 are kept in flops for decoding
   localparam int unsigned FIELD_BASE  = 3;
   localparam int unsigned FIELD_BYTES = 8;
   // first LED state byte of a run
   localparam int unsigned RUN_FIRST  = 4;
   // smallest length code that gives a non-empty LED run
   localparam logic [7:0]  RUN_MIN_LEN = 8'd2;

   // descriptor queue depth
   localparam int unsigned QUEUE_DEPTH = 2;

   // configuration port
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic [0:0]  REG_HOST_ADDRESS = 1'b0;

   // command codes
   localparam logic [7:0] CMD_OPEN         = 8'h20;
   localparam logic [7:0] CMD_STATUS_QUERY = 8'h21;
   localparam logic [7:0] CMD_OPEN_ALL     = 8'h22;
   localparam logic [7:0] CMD_SET_TIME     = 8'h23;
   localparam logic [7:0] CMD_ACK_25       = 8'h25;
   localparam logic [7:0] CMD_EXT_QUERY    = 8'h26;
   localparam logic [7:0] CMD_EXT_OPEN     = 8'h27;
   localparam logic [7:0] CMD_ACK_28       = 8'h28;
   localparam logic [7:0] CMD_ACK_29       = 8'h29;
   localparam logic [7:0] CMD_LED_STATE    = 8'h2A;
   localparam logic [7:0] CMD_SCALE_READ   = 8'h2B;

   // codes inside data bytes
   localparam logic [7:0] TEMP_CODE_OK    = 8'h00;
   localparam logic [7:0] TEMP_CODE_OVER  = 8'h01;
   localparam logic [7:0] TEMP_CODE_FAULT = 8'h02;
   localparam logic [7:0] SET_TIME_FAILED = 8'h01;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_DATA_ERR      = 3'd1,
      ST_UNKNOWN_CMD   = 3'd2,
      ST_TEMP_OVER     = 3'd3,
      ST_TEMP_FAULT    = 3'd4,
      ST_SET_TIME_FAIL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      DK_HANDSHAKE = 2'd0,
      DK_ERROR     = 2'd1,
      DK_FRAME     = 2'd2
   } desc_kind_type;

   // one classified item; fb[j] is frame byte j + 3, zero past the frame end
   typedef struct packed {
      desc_kind_type                  kind;
      logic [7:0]                     len;
      logic [FIELD_BYTES-1:0][7:0]    fb;
   } desc_type;

   typedef struct packed {
      status_type  status;
      logic        handshake_seen;
      logic [7:0]  command;
      logic [7:0]  lead_byte;
      logic [15:0] contact_state;
      logic [7:0]  open_time;
      logic [7:0]  retry_time;
      logic [7:0]  temperature;
      logic [7:0]  gun_state;
      logic [7:0]  door_state;
      logic [31:0] weight;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/lbrd_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_req_if: received byte channel
// Valid/ready channel carrying one serial byte and the handshake flag.
// ---------------------------------------------------------------------------
interface lbrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       expect_handshake;

   modport source (output valid, output rx_byte, output expect_handshake, input ready);
   modport sink   (input valid, input rx_byte, input expect_handshake, output ready);
endinterface

>>> rtl/lbrd_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_rsp_if: decoded response channel
// Valid/ready channel carrying one decoded result item.
// ---------------------------------------------------------------------------
interface lbrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        handshake_seen;
   logic [7:0]  command;
   logic [7:0]  lead_byte;
   logic [15:0] contact_state;
   logic [7:0]  open_time;
   logic [7:0]  retry_time;
   logic [7:0]  temperature;
   logic [7:0]  gun_state;
   logic [7:0]  door_state;
   logic [31:0] weight;
   logic        last;

   modport source (output valid, output status, output handshake_seen, output command,
                   output lead_byte, output contact_state, output open_time,
                   output retry_time, output temperature, output gun_state,
                   output door_state, output weight, output last, input ready);
   modport sink   (input valid, input status, input handshake_seen, input command,
                   input lead_byte, input contact_state, input open_time,
                   input retry_time, input temperature, input gun_state,
                   input door_state, input weight, input last, output ready);
endinterface

>>> rtl/lock_board_response_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lock_board_response_deframer: lock board response deframer
// Assembles received bytes into response frames, checks the xor byte and
// decodes each frame into one result item, or a run of LED state items.
//
//   channel    direction  protocol          payload
//   req_chan   in         valid/ready       rx_byte, expect_handshake
//   rsp_chan   out        valid/ready       decoded result item
//   psel...    in/out     apb, 32-bit data  host_address at byte 0
//
// Each descriptor is registered in the queue, then its single result in the
// output register. An LED state run reads its items one by one through the
// buffer read port. Intake stalls while the descriptor queue is full and
// while an LED run is pending. Reset is synchronous; the frame buffer is
// not cleared, only bytes of the current frame are read.
// ---------------------------------------------------------------------------
module lock_board_response_deframer #(
   parameter int unsigned MAX_FRAME = lbrd_pkg::MAX_FRAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lbrd_req_if.sink                        req_chan,
   lbrd_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lbrd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import lbrd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);

   logic [7:0]    host_ff, host_in;
   logic          push_valid;
   logic          push_ready;
   desc_type      push_desc;
   logic          pop_valid;
   logic          pop_ready;
   desc_type      pop_desc;
   logic          run_done;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // configuration register
   assign pready = 1'b1;

   always_comb begin
      host_in = host_ff;
      if (psel && penable && pwrite && (paddr[CSR_ADDR_W-1:2] == REG_HOST_ADDRESS)) begin
         host_in = pwdata[7:0];
      end
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_HOST_ADDRESS) begin
         prdata = {24'd0, host_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff <= '0;
      end else begin
         host_ff <= host_in;
      end
   end

   lbrd_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .host_address (host_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_desc    (push_desc),
      .run_done     (run_done),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   lbrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   lbrd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_desc  (pop_desc),
      .run_done  (run_done),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> rtl/lbrd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_front: byte intake and frame classifier
// Buffers frame bytes, tracks length and running xor, and pushes one
// descriptor per handshake, error or completed frame.
// ---------------------------------------------------------------------------
module lbrd_front #(
   parameter int unsigned MAX_FRAME = lbrd_pkg::MAX_FRAME_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   lbrd_req_if.sink                     req_chan,
   input  logic [7:0]                   host_address,
   output logic                         push_valid,
   input  logic                         push_ready,
   output lbrd_pkg::desc_type           push_desc,
   input  logic                         run_done,
   input  logic [$clog2(MAX_FRAME)-1:0] rd_addr,
   output logic [7:0]                   rd_data
);
   import lbrd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   logic [7:0]    mem [MAX_FRAME];
   logic [7:0]    rd_data_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    len_ff, len_in;
   logic          led_pend_ff, led_pend_in;
   logic [FIELD_BYTES-1:0][7:0] fb_ff, fb_in;

   logic              accept;
   logic              hs_hit;
   logic              full_err;
   logic              size_err;
   logic              at_end;
   logic              wr_en;
   logic [7:0]        len_now;
   logic [7:0]        xor_now;
   logic [TOT_W-1:0]  cnt_ext;
   logic [TOT_W-1:0]  total;
   logic [FIELD_BYTES-1:0][7:0] fb_now;
   logic              is_run;

   assign req_chan.ready = push_ready & ~led_pend_ff;
   assign accept         = req_chan.valid & req_chan.ready;

   // classify the incoming byte
   always_comb begin
      hs_hit   = req_chan.expect_handshake && (count_ff == '0)
                 && (req_chan.rx_byte == host_address);
      full_err = (count_ff >= CW'(MAX_FRAME));
      len_now  = (count_ff == CW'(2)) ? req_chan.rx_byte : len_ff;
      total    = TOT_W'(len_now) + TOT_W'(HDR_BYTES);
      cnt_ext  = TOT_W'(count_ff) + TOT_W'(1);
      size_err = (count_ff == CW'(2)) && (total > TOT_W'(MAX_FRAME));
      at_end   = (count_ff >= CW'(2)) && (cnt_ext == total);
      xor_now  = xor_ff ^ req_chan.rx_byte;
      for (int j = 0; j < FIELD_BYTES; j++) begin
         fb_now[j] = (count_ff == CW'(j + FIELD_BASE)) ? req_chan.rx_byte : fb_ff[j];
         if (len_ff < 8'(j)) begin
            fb_now[j] = '0;
         end
      end
      is_run = (fb_now[0] == CMD_LED_STATE) && (len_ff >= RUN_MIN_LEN);
   end

   // descriptor and next state
   always_comb begin
      count_in    = count_ff;
      xor_in      = xor_ff;
      len_in      = len_ff;
      fb_in       = fb_ff;
      led_pend_in = led_pend_ff & ~run_done;
      wr_en       = 1'b0;
      push_valid  = 1'b0;
      push_desc.kind = DK_ERROR;
      push_desc.len  = len_ff;
      push_desc.fb   = fb_now;
      if (accept) begin
         if (hs_hit) begin
            push_valid     = 1'b1;
            push_desc.kind = DK_HANDSHAKE;
         end else if (full_err) begin
            push_valid = 1'b1;
            count_in   = '0;
            xor_in     = '0;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            xor_in   = xor_now;
            len_in   = len_now;
            fb_in    = fb_now;
            if (size_err) begin
               push_valid = 1'b1;
               count_in   = '0;
               xor_in     = '0;
            end else if (at_end) begin
               push_valid = 1'b1;
               count_in   = '0;
               xor_in     = '0;
               if (xor_now == '0) begin
                  push_desc.kind = DK_FRAME;
                  led_pend_in    = is_run;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         xor_ff      <= '0;
         led_pend_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         led_pend_ff <= led_pend_in;
      end
   end

   // field bytes and length code
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      fb_ff  <= fb_in;
   end

   // frame buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_chan.rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lbrd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_queue: descriptor queue
// Short register queue between the classifier and the response builder.
// ---------------------------------------------------------------------------
module lbrd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lbrd_pkg::desc_type push_desc,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lbrd_pkg::desc_type pop_desc
);
   import lbrd_pkg::*;

   localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

   desc_type         slot [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != QCW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = slot[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCW'(1);
         2'b01:   count_in = count_ff - QCW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

>>> rtl/lbrd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbrd_back: response builder
// Decodes descriptors by command, walks LED state runs through the frame
// buffer read port and holds each result in an output register.
// ---------------------------------------------------------------------------
module lbrd_back #(
   parameter int unsigned MAX_FRAME = lbrd_pkg::MAX_FRAME_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  lbrd_pkg::desc_type           pop_desc,
   output logic                         run_done,
   output logic [$clog2(MAX_FRAME)-1:0] rd_addr,
   input  logic [7:0]                   rd_data,
   lbrd_rsp_if.source                   rsp_chan
);
   import lbrd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);

   typedef enum logic [2:0] {
      BS_IDLE = 3'b001,
      BS_READ = 3'b010,
      BS_EMIT = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [AW-1:0]  end_ff, end_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           out_free;
   logic           head_is_run;
   logic           run_last;
   logic [7:0]     cmd;
   rsp_type        single_rsp;
   rsp_type        run_rsp;

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   assign cmd      = pop_desc.fb[0];
   assign run_last = (addr_ff == end_ff);
   assign rd_addr  = addr_ff;

   assign head_is_run = (pop_desc.kind == DK_FRAME) && (cmd == CMD_LED_STATE)
                        && (pop_desc.len >= RUN_MIN_LEN);

   // single result decode of the queue head
   always_comb begin
      single_rsp      = '0;
      single_rsp.last = 1'b1;
      unique case (pop_desc.kind)
         DK_HANDSHAKE: single_rsp.handshake_seen = 1'b1;
         DK_ERROR:     single_rsp.status = ST_DATA_ERR;
         default: begin
            single_rsp.command   = cmd;
            single_rsp.lead_byte = pop_desc.fb[1];
            unique case (cmd) inside
               CMD_OPEN, CMD_OPEN_ALL, CMD_ACK_25, CMD_ACK_28, CMD_ACK_29: begin
               end
               CMD_STATUS_QUERY: begin
                  single_rsp.contact_state = {pop_desc.fb[2], pop_desc.fb[3]};
                  single_rsp.open_time     = pop_desc.fb[4];
                  single_rsp.retry_time    = pop_desc.fb[5];
                  if (pop_desc.fb[6] == TEMP_CODE_OK) begin
                     single_rsp.temperature = pop_desc.fb[7];
                  end else if (pop_desc.fb[6] == TEMP_CODE_OVER) begin
                     single_rsp.status = ST_TEMP_OVER;
                  end else if (pop_desc.fb[6] == TEMP_CODE_FAULT) begin
                     single_rsp.status = ST_TEMP_FAULT;
                  end
               end
               CMD_SET_TIME: begin
                  if (pop_desc.fb[1] == SET_TIME_FAILED) begin
                     single_rsp.status = ST_SET_TIME_FAIL;
                  end
               end
               CMD_EXT_QUERY: begin
                  single_rsp.gun_state  = pop_desc.fb[2];
                  single_rsp.door_state = pop_desc.fb[3];
               end
               CMD_EXT_OPEN: single_rsp.gun_state = pop_desc.fb[2];
               // empty LED run reports one item with no state byte
               CMD_LED_STATE: single_rsp.lead_byte = '0;
               CMD_SCALE_READ: begin
                  single_rsp.weight = {pop_desc.fb[2], pop_desc.fb[3],
                                       pop_desc.fb[4], pop_desc.fb[5]};
               end
               default: begin
                  single_rsp         = '0;
                  single_rsp.status  = ST_UNKNOWN_CMD;
                  single_rsp.command = cmd;
                  single_rsp.last    = 1'b1;
               end
            endcase
         end
      endcase
   end

   // one LED state item of a run
   always_comb begin
      run_rsp           = '0;
      run_rsp.command   = CMD_LED_STATE;
      run_rsp.lead_byte = rd_data;
      run_rsp.last      = run_last;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      pop_ready    = 1'b0;
      run_done     = 1'b0;
      unique case (state_ff)
         BS_IDLE: begin
            if (pop_valid) begin
               if (head_is_run) begin
                  pop_ready = 1'b1;
                  addr_in   = AW'(RUN_FIRST);
                  end_in    = AW'({1'b0, pop_desc.len} + 9'd2);
                  state_in  = BS_READ;
               end else if (out_free) begin
                  pop_ready    = 1'b1;
                  rsp_in       = single_rsp;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BS_READ: state_in = BS_EMIT;
         BS_EMIT: begin
            if (out_free) begin
               rsp_in       = run_rsp;
               rsp_valid_in = 1'b1;
               if (run_last) begin
                  run_done = 1'b1;
                  state_in = BS_IDLE;
               end else begin
                  addr_in  = addr_ff + AW'(1);
                  state_in = BS_READ;
               end
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      end_ff  <= end_in;
      rsp_ff  <= rsp_in;
   end

   // output channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.handshake_seen = rsp_ff.handshake_seen;
   assign rsp_chan.command        = rsp_ff.command;
   assign rsp_chan.lead_byte      = rsp_ff.lead_byte;
   assign rsp_chan.contact_state  = rsp_ff.contact_state;
   assign rsp_chan.open_time      = rsp_ff.open_time;
   assign rsp_chan.retry_time     = rsp_ff.retry_time;
   assign rsp_chan.temperature    = rsp_ff.temperature;
   assign rsp_chan.gun_state      = rsp_ff.gun_state;
   assign rsp_chan.door_state     = rsp_ff.door_state;
   assign rsp_chan.weight         = rsp_ff.weight;
   assign rsp_chan.last           = rsp_ff.last;

endmodule

>>> tb/lock_board_response_deframer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lock_board_response_deframer_tb: self-checking bench of the response deframer
// Feeds received bytes, handshake replies, well-formed frames of every command,
// broken frames and noise, with random gaps and back-pressure. A software copy
// of the deframer predicts every result item, which is checked field by field.
// ---------------------------------------------------------------------------
module lock_board_response_deframer_tb;
   import lbrd_pkg::*;

   localparam int FRAME_CAP      = MAX_FRAME_DEF;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] HOST_ADDRESS_ADDR = CSR_ADDR_W'(4 * REG_HOST_ADDRESS);

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;
   logic rsp_ready_q = 1'b0;

   lbrd_req_if req_if ();
   lbrd_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready_q;

   lock_board_response_deframer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // deframer state as the bench sees it
   logic [7:0] frame_mem [FRAME_CAP];
   int         rx_count;
   logic [7:0] rx_xor;
   logic [7:0] host_addr;
   rsp_type    pending_rsp [$];
   rsp_type    expected_item;

   int fail_count = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   int sink_stall = 0;
   bit calm = 1'b0;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // frame byte, zero past the end of the frame
   function automatic logic [7:0] frame_byte(int idx, int total);
      return (idx < total && idx < FRAME_CAP) ? frame_mem[idx] : 8'h00;
   endfunction

   function automatic void push_data_error();
      rsp_type r;
      r = '0;
      r.status = ST_DATA_ERR;
      r.last = 1'b1;
      pending_rsp.push_back(r);
      rx_count = 0;
      rx_xor = 8'h00;
   endfunction

   // work out the result items one received byte causes
   function automatic void deframe_byte(logic [7:0] b, logic hs);
      rsp_type    r;
      int         total;
      int         run_len;
      int         i;
      logic [7:0] cmd;
      logic [7:0] temp_code;
      r = '0;
      r.last = 1'b1;
      // lone host address while a handshake is awaited
      if (hs && rx_count == 0 && b == host_addr) begin
         r.handshake_seen = 1'b1;
         pending_rsp.push_back(r);
         return;
      end
      if (rx_count >= FRAME_CAP) begin
         push_data_error();
         return;
      end
      frame_mem[rx_count] = b;
      rx_count++;
      rx_xor ^= b;
      if (rx_count < 3) return;
      total = int'(frame_mem[2]) + HDR_BYTES;
      if (total > FRAME_CAP) begin
         push_data_error();
         return;
      end
      if (rx_count < total) return;
      if (rx_xor != 8'h00) begin
         push_data_error();
         return;
      end
      rx_count = 0;
      cmd = frame_byte(3, total);
      r.command = cmd;
      r.lead_byte = frame_byte(4, total);
      case (cmd)
         CMD_OPEN, CMD_OPEN_ALL, CMD_ACK_25, CMD_ACK_28, CMD_ACK_29: ;
         CMD_STATUS_QUERY: begin
            temp_code = frame_byte(9, total);
            r.contact_state = {frame_byte(5, total), frame_byte(6, total)};
            r.open_time = frame_byte(7, total);
            r.retry_time = frame_byte(8, total);
            if (temp_code == TEMP_CODE_OK) r.temperature = frame_byte(10, total);
            else if (temp_code == TEMP_CODE_OVER) r.status = ST_TEMP_OVER;
            else if (temp_code == TEMP_CODE_FAULT) r.status = ST_TEMP_FAULT;
         end
         CMD_SET_TIME: begin
            if (frame_byte(4, total) == SET_TIME_FAILED) r.status = ST_SET_TIME_FAIL;
         end
         CMD_EXT_QUERY: begin
            r.gun_state = frame_byte(5, total);
            r.door_state = frame_byte(6, total);
         end
         CMD_EXT_OPEN: r.gun_state = frame_byte(5, total);
         CMD_LED_STATE: begin
            run_len = (frame_mem[2] >= 8'd1) ? int'(frame_mem[2]) - 1 : 0;
            if (run_len == 0) begin
               r.lead_byte = 8'h00;
            end else begin
               for (i = 0; i < run_len; i++) begin
                  r.lead_byte = frame_byte(i + RUN_FIRST, total);
                  r.last = (i + 1 == run_len);
                  pending_rsp.push_back(r);
               end
               return;
            end
         end
         CMD_SCALE_READ: begin
            r.weight = {frame_byte(5, total), frame_byte(6, total),
                        frame_byte(7, total), frame_byte(8, total)};
         end
         default: begin
            r = '0;
            r.status = ST_UNKNOWN_CMD;
            r.command = cmd;
            r.last = 1'b1;
         end
      endcase
      pending_rsp.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result item with none expected");
            fail_count++;
         end else begin
            expected_item = pending_rsp.pop_front();
            check_field("status", expected_item.status, rsp_if.status);
            check_field("handshake_seen", expected_item.handshake_seen, rsp_if.handshake_seen);
            check_field("command", expected_item.command, rsp_if.command);
            check_field("lead_byte", expected_item.lead_byte, rsp_if.lead_byte);
            check_field("contact_state", expected_item.contact_state, rsp_if.contact_state);
            check_field("open_time", expected_item.open_time, rsp_if.open_time);
            check_field("retry_time", expected_item.retry_time, rsp_if.retry_time);
            check_field("temperature", expected_item.temperature, rsp_if.temperature);
            check_field("gun_state", expected_item.gun_state, rsp_if.gun_state);
            check_field("door_state", expected_item.door_state, rsp_if.door_state);
            check_field("weight", expected_item.weight, rsp_if.weight);
            check_field("last", expected_item.last, rsp_if.last);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (sink_stall > 0) begin
         sink_stall--;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // send one byte item, predict its results, then maybe idle
   task automatic send_byte(input logic [7:0] b, input logic hs);
      int gap;
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      req_if.expect_handshake <= hs;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      deframe_byte(b, hs);
      items_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every expected item is back and the block has settled
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // push bytes until no partial frame is buffered
   task automatic close_frame();
      while (rx_count != 0)
         send_byte((rx_count == 2) ? 8'hFF : 8'($urandom()), 1'b0);
   endtask

   task automatic set_host_address(input logic [7:0] value);
      close_frame();
      drain_responses();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= HOST_ADDRESS_ADDR;
      pwdata <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      host_addr = value;
   endtask

   // build a frame of length code len; data[0] is byte 4
   task automatic send_frame(input logic [7:0] cmd, input int len,
                             input logic [0:7][7:0] data, input bit bad_check);
      logic [7:0] fr [FRAME_CAP];
      logic [7:0] chk;
      int         total;
      int         i;
      total = (len + HDR_BYTES > FRAME_CAP) ? 3 : len + HDR_BYTES;
      fr[0] = 8'($urandom());
      fr[1] = 8'($urandom());
      fr[2] = 8'(len);
      fr[3] = cmd;
      for (i = 4; i <= total - 2; i++)
         fr[i] = (i < 12) ? data[i-4] : 8'($urandom());
      if (total > 3) begin
         // with no data the check byte doubles as the command
         if (len == 0) fr[1] = cmd ^ fr[0];
         chk = 8'h00;
         for (i = 0; i < total - 1; i++) chk ^= fr[i];
         if (bad_check) chk ^= 8'(1 << $urandom_range(0, 7));
         fr[total-1] = chk;
      end
      for (i = 0; i < total; i++)
         send_byte(fr[i], (fr[i] == host_addr) ? 1'b0 : 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [0:7][7:0] random_data();
      logic [0:7][7:0] d;
      d = {$urandom(), $urandom()};
      if ($urandom_range(0, 1) != 0) d[0] = SET_TIME_FAILED;
      if ($urandom_range(0, 3) != 0) d[5] = 8'($urandom_range(TEMP_CODE_OK, TEMP_CODE_FAULT));
      return d;
   endfunction

   function automatic logic [7:0] random_command();
      case ($urandom_range(0, 12))
         0: return CMD_OPEN;
         1: return CMD_STATUS_QUERY;
         2: return CMD_OPEN_ALL;
         3: return CMD_SET_TIME;
         4: return CMD_ACK_25;
         5: return CMD_EXT_QUERY;
         6: return CMD_EXT_OPEN;
         7: return CMD_ACK_28;
         8: return CMD_ACK_29;
         9: return CMD_LED_STATE;
         10: return CMD_SCALE_READ;
         default: return 8'($urandom());
      endcase
   endfunction

   // handshake replies, and host bytes that must be taken as frame bytes
   task automatic test_handshake();
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      close_frame();
      send_byte(8'h5A, 1'b1);
      send_byte(8'h00, 1'b1);
      close_frame();
      set_host_address(8'hFF);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);
      set_host_address(8'h00);
   endtask

   // one frame of each command but status query and LED state, and unknown ones
   task automatic test_commands();
      send_frame(CMD_OPEN, 2, {8'h01, 56'h0}, 1'b0);
      send_frame(CMD_OPEN_ALL, 3, {8'hFF, 8'h12, 48'h0}, 1'b0);
      send_frame(CMD_ACK_25, 2, {8'h80, 56'h0}, 1'b0);
      send_frame(CMD_ACK_28, 0, 64'h0, 1'b0);
      send_frame(CMD_ACK_29, 1, 64'h0, 1'b0);
      send_frame(CMD_SET_TIME, 2, {SET_TIME_FAILED, 56'h0}, 1'b0);
      send_frame(CMD_SET_TIME, 2, {8'h00, 56'h0}, 1'b0);
      send_frame(CMD_EXT_QUERY, 4, {8'h03, 8'hFF, 8'h00, 40'h0}, 1'b0);
      send_frame(CMD_EXT_OPEN, 3, {8'h09, 8'h01, 48'h0}, 1'b0);
      send_frame(CMD_SCALE_READ, 6, {8'h02, 32'hFFFF_FFFE, 24'h0}, 1'b0);
      send_frame(8'h00, 2, random_data(), 1'b0);
      send_frame(8'hFF, 5, random_data(), 1'b0);
   endtask

   // query temperature codes, and a query frame too short for its fields
   task automatic test_query_codes();
      send_frame(CMD_STATUS_QUERY, 8,
                 {8'h07, 16'hFFFF, 8'h3C, 8'hC3, TEMP_CODE_OK, 8'hE1, 8'h0}, 1'b0);
      send_frame(CMD_STATUS_QUERY, 8,
                 {8'h01, 16'h0001, 8'hFF, 8'h00, TEMP_CODE_OVER, 8'hE1, 8'h0}, 1'b0);
      send_frame(CMD_STATUS_QUERY, 8,
                 {8'h02, 16'h8000, 8'h00, 8'hFF, TEMP_CODE_FAULT, 8'h7E, 8'h0}, 1'b0);
      send_frame(CMD_STATUS_QUERY, 8,
                 {8'h03, 16'h1234, 8'h10, 8'h20, 8'h7F, 8'h55, 8'h0}, 1'b0);
      send_frame(CMD_STATUS_QUERY, 5, {8'h04, 16'hABCD, 8'h11, 8'h22, 24'h0}, 1'b0);
   endtask

   // LED runs: empty, single, short and the longest that fits
   task automatic test_led_runs();
      send_frame(CMD_LED_STATE, 0, 64'h0, 1'b0);
      send_frame(CMD_LED_STATE, 1, random_data(), 1'b0);
      send_frame(CMD_LED_STATE, 2, random_data(), 1'b0);
      send_frame(CMD_LED_STATE, 5, random_data(), 1'b0);
      send_frame(CMD_LED_STATE, FRAME_CAP - HDR_BYTES, random_data(), 1'b0);
   endtask

   // check byte mismatch and oversize frames
   task automatic test_frame_errors();
      send_frame(CMD_OPEN, 4, random_data(), 1'b1);
      send_frame(CMD_STATUS_QUERY, 0, 64'h0, 1'b1);
      send_frame(CMD_OPEN, FRAME_CAP - HDR_BYTES + 1, random_data(), 1'b0);
      send_frame(CMD_OPEN, 255, random_data(), 1'b0);
   endtask

   // mostly well-formed frames, with noise, broken frames and handshakes
   task automatic test_random_traffic(input logic [7:0] host, input int n_items);
      int stop_at;
      int pick;
      calm = 1'b0;
      set_host_address(host);
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) != 0) close_frame();
         end else if (pick < 16) begin
            close_frame();
            send_byte(($urandom_range(0, 3) != 0) ? host_addr : 8'($urandom()), 1'b1);
         end else if (pick < 22) begin
            send_frame(random_command(), $urandom_range(0, 12), random_data(), 1'b1);
         end else if (pick < 26) begin
            send_frame(random_command(), $urandom_range(61, 255), random_data(), 1'b0);
         end else if (pick < 29) begin
            send_frame(CMD_LED_STATE, $urandom_range(13, 60), random_data(), 1'b0);
         end else if (pick < 31) begin
            drain_responses();
         end else if (pick < 34) begin
            calm = !calm;
         end else begin
            send_frame(random_command(), $urandom_range(0, 12), random_data(), 1'b0);
         end
      end
      close_frame();
   endtask

   // reset, directed tests, random phases, final check
   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= 8'h00;
      req_if.expect_handshake <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= 32'h0;
      rx_count = 0;
      rx_xor = 8'h00;
      host_addr = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_handshake();
      test_commands();
      test_query_codes();
      test_led_runs();
      test_frame_errors();
      test_random_traffic(8'hFF, 8);
      test_random_traffic(8'($urandom()), 8);
      test_random_traffic(8'h00, 8);

      drain_responses();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
